// ----- design/egbr_pkg.sv -----
package egbr_pkg;

  localparam int MAX_PARTS   = 8;
  localparam int NUM_CUTS    = 7;
  localparam int PART_CAP    = (MAX_PARTS < NUM_CUTS + 1) ? MAX_PARTS : NUM_CUTS + 1;
  localparam int NUM_BUCKETS = MAX_PARTS * MAX_PARTS;
  localparam int BUCKET_W    = 6;
  localparam int SLOT_W      = 32;
  localparam int VERTEX_W    = 32;
  localparam int PCOUNT_W    = 4;
  localparam int PART_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 3'd0;

  typedef struct packed {
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
    logic                last_edge;
  } in_req_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic [VERTEX_W-1:0] out_src;
    logic [VERTEX_W-1:0] out_dst;
    logic                out_last;
  } out_req_t;

  typedef struct packed {
    logic [PCOUNT_W-1:0]                parts;
    logic [NUM_CUTS-1:0][VERTEX_W-1:0] cuts;
  } cfg_t;

endpackage

// ----- design/egbr_cfg.sv -----
module egbr_cfg import egbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [PCOUNT_W-1:0]                part_count_r;
  logic [NUM_CUTS-1:0][VERTEX_W-1:0] cuts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= PCOUNT_W'(1);
      cuts_r       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_PART_COUNT) begin
        part_count_r <= cfg_wdata[PCOUNT_W-1:0];
      end else begin
        cuts_r[cfg_index - CFG_IDX_W'(1)] <= cfg_wdata[VERTEX_W-1:0];
      end
    end
  end

  always_comb begin
    cfg.cuts = cuts_r;
    if (part_count_r == '0) begin
      cfg.parts = PCOUNT_W'(1);
    end else if (part_count_r > PCOUNT_W'(PART_CAP)) begin
      cfg.parts = PCOUNT_W'(PART_CAP);
    end else begin
      cfg.parts = part_count_r;
    end
  end

endmodule

// ----- design/egbr_locate.sv -----
module egbr_locate import egbr_pkg::*; (
  input  cfg_t                cfg,
  input  logic [VERTEX_W-1:0] src_vertex,
  input  logic [VERTEX_W-1:0] dst_vertex,
  output logic [BUCKET_W-1:0] bucket
);

  logic [PART_W-1:0] limit;
  logic [PART_W-1:0] row;
  logic [PART_W-1:0] col;
  logic              row_run;
  logic              col_run;

  assign limit = PART_W'(cfg.parts - PCOUNT_W'(1));

  always_comb begin
    row     = '0;
    col     = '0;
    row_run = 1'b1;
    col_run = 1'b1;
    for (int i = 0; i < NUM_CUTS; i++) begin
      if (row_run && (PART_W'(i) < limit) && (src_vertex >= cfg.cuts[i])) begin
        row = PART_W'(i + 1);
      end else begin
        row_run = 1'b0;
      end
      if (col_run && (PART_W'(i) < limit) && (dst_vertex >= cfg.cuts[i])) begin
        col = PART_W'(i + 1);
      end else begin
        col_run = 1'b0;
      end
    end
  end

  assign bucket = BUCKET_W'(row) * BUCKET_W'(cfg.parts) + BUCKET_W'(col);

endmodule

// ----- design/egbr_fill_mem.sv -----
module egbr_fill_mem import egbr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [BUCKET_W-1:0] rd_addr,
  output logic [SLOT_W-1:0]   rd_data,
  input  logic                wr_en,
  input  logic [BUCKET_W-1:0] wr_addr,
  input  logic [SLOT_W-1:0]   wr_data
);

  logic [SLOT_W-1:0]      mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid_r;
  logic [SLOT_W-1:0]      rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- design/edge_grid_bucket_router.sv -----
// An accepted request is registered in stage 1, where its bucket counter is
// read, and then in the output register, from which its result is offered.
// Throughput: one request per cycle unless the output stalls; the bucket counter
// memory is read at acceptance and written back as the request leaves stage 1,
// with forwarding between consecutive requests to the same bucket.
// Reset (synchronous, active low) restores the configuration defaults and
// clears all bucket counters at once through per-bucket valid bits.
module edge_grid_bucket_router import egbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_req_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                cfg;
  logic [BUCKET_W-1:0] in_bucket;
  logic                in_acc;
  logic                s1_adv;
  logic                s1_valid_r;
  in_req_t             s1_req_r;
  logic [BUCKET_W-1:0] s1_bucket_r;
  logic [SLOT_W-1:0]   mem_rd_data;
  logic [SLOT_W-1:0]   cnt;
  logic                fwd_hit_r;
  logic                fwd_hit_nxt;
  logic [SLOT_W-1:0]   fwd_val_r;
  logic                out_valid_r;
  out_req_t            out_data_r;

  egbr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  egbr_locate u_locate (
    .cfg        (cfg),
    .src_vertex (in_data.src_vertex),
    .dst_vertex (in_data.dst_vertex),
    .bucket     (in_bucket)
  );

  egbr_fill_mem u_fill_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_bucket),
    .rd_data (mem_rd_data),
    .wr_en   (s1_valid_r && s1_adv),
    .wr_addr (s1_bucket_r),
    .wr_data (cnt + SLOT_W'(1))
  );

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign cnt      = fwd_hit_r ? fwd_val_r : mem_rd_data;

  assign fwd_hit_nxt = s1_valid_r && s1_adv && (in_bucket == s1_bucket_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_acc) begin
        fwd_hit_r <= fwd_hit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r    <= in_data;
      s1_bucket_r <= in_bucket;
      fwd_val_r   <= cnt + SLOT_W'(1);
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r.bucket   <= s1_bucket_r;
      out_data_r.slot     <= cnt;
      out_data_r.out_src  <= s1_req_r.src_vertex;
      out_data_r.out_dst  <= s1_req_r.dst_vertex;
      out_data_r.out_last <= s1_req_r.last_edge;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fwd_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fwd_hit_nxt |=> fwd_hit_r && (cnt == $past(cnt) + SLOT_W'(1)))
    else $error("Back-to-back requests to one bucket did not see the updated count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_bucket_r) && $stable(cnt))
    else $error("Held request lost its bucket or count");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv |=> out_valid_r && (out_data_r.bucket == $past(s1_bucket_r)))
    else $error("Advancing request did not reach the output register");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("Input stalled with an empty pipeline stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r && !fwd_hit_r)
    else $error("Pipeline not empty after reset");

endmodule
